[rtl/kmtc_pkg.sv]
// Shared types, sizes and codes for the two-cluster k-means block.
package kmtc_pkg;

  localparam int COORD_W    = 16;
  localparam int MAX_POINTS = 1024;
  localparam int PIDX_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = PIDX_W + 1;
  localparam int SUM_W      = COORD_W + PIDX_W;
  localparam int Q_W        = COORD_W + 1;
  localparam int REM_W      = Q_W + 3;
  localparam int ARG_W      = 2 * Q_W;
  localparam int DIST_W     = 2 * COORD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 88;

  localparam logic [Q_W-1:0] START_SHIFT = Q_W'(99999);

  localparam logic signed [COORD_W-1:0] RST_C0_X = 16'sd0;
  localparam logic signed [COORD_W-1:0] RST_C0_Y = 16'sd0;
  localparam logic signed [COORD_W-1:0] RST_C1_X = 16'sd256;
  localparam logic signed [COORD_W-1:0] RST_C1_Y = 16'sd256;
  localparam logic [15:0] RST_THRESHOLD = 16'd512;
  localparam logic [7:0]  RST_CAP       = 8'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C0_X = 3'd0,
    REG_C0_Y = 3'd1,
    REG_C1_X = 3'd2,
    REG_C1_Y = 3'd3,
    REG_THR  = 3'd4,
    REG_CAP  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } iter_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_RESP, S_PINIT, S_FETCH, S_DIST, S_ASSIGN,
    S_UPD, S_DIV, S_DIVW, S_SD, S_SQ, S_SQW, S_PEND
  } state_e;

endpackage

[rtl/kmtc_iter.sv]
// Shared shift-subtract unit: restoring divide or integer square root, one bit a cycle.
module kmtc_iter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kmtc_pkg::iter_req_t      req_i,
  input  logic [kmtc_pkg::ARG_W-1:0] arg_i,
  input  logic [kmtc_pkg::CNT_W-1:0] den_i,
  output logic                     done_o,
  output logic [kmtc_pkg::Q_W-1:0] res_o
);
  import kmtc_pkg::*;

  localparam int CNT_BITS = $clog2(Q_W + 1);

  logic                busy_q, done_q;
  unit_op_e            op_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [ARG_W-1:0]    sh_q;
  logic [REM_W-1:0]    rem_q, rem_sh, trial, diff, rem_d;
  logic [Q_W-1:0]      q_q;
  logic [CNT_W-1:0]    den_q;
  logic                ge;

  always_comb begin
    if (op_q == OP_DIV) begin
      rem_sh = {rem_q[REM_W-2:0], sh_q[ARG_W-1]};
      trial  = REM_W'(den_q);
    end else begin
      rem_sh = {rem_q[REM_W-3:0], sh_q[ARG_W-1:ARG_W-2]};
      trial  = REM_W'({q_q, 2'b01});
    end
    diff  = rem_sh - trial;
    ge    = rem_sh >= trial;
    rem_d = ge ? diff : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(Q_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      den_q <= den_i;
      q_q   <= '0;
      if (req_i.op == OP_DIV) begin
        // quotient is known to fit Q_W bits, so the top part is already below den
        rem_q <= REM_W'(arg_i[SUM_W-1:Q_W]);
        sh_q  <= {arg_i[Q_W-1:0], {(ARG_W-Q_W){1'b0}}};
      end else begin
        rem_q <= '0;
        sh_q  <= arg_i;
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      q_q   <= {q_q[Q_W-2:0], ge};
      sh_q  <= (op_q == OP_DIV) ? {sh_q[ARG_W-2:0], 1'b0} : {sh_q[ARG_W-3:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign res_o  = q_q;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("iter unit restarted while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("iter done while still busy");
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && !done_q)
    else $error("iter did not go busy after start");
`endif

endmodule

[rtl/kmeans_two_cluster_2d.sv]
// Two-cluster 2-D k-means: point store, sequencer, shared multiplier and divide/sqrt unit.
// Load and clear: the beat leads to S_RESP, which registers the result; a read goes through S_READ first.
// Run over N points, repeated each pass: each point takes one memory fetch, the squared
// distances to both centroids on the shared multiplier and an update; each non-empty
// centroid two divides and one square root on the shared 17-step unit. One command at a time.
// Reset: async active low; registers, centroids and counters reset; no clearing pass,
// the point and class memories are only read below the point count.
module kmeans_two_cluster_2d (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kmtc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kmtc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coord_x [15:0], coord_y [31:16], point_index [41:32]
  input  logic [kmtc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // command [1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cluster_id [0], points_held [11:1], passes_done [19:12], converged [20],
  // cent0_x [36:21], cent0_y [52:37], cent1_x [68:53], cent1_y [84:69]
  output logic [kmtc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status [1:0]
  output logic [1:0]                          m_axis_tuser
);
  import kmtc_pkg::*;

  state_e state_q, state_d;

  logic signed [COORD_W-1:0] ic_q [4];
  logic [15:0]               thr_q;
  logic [7:0]                cap_q;

  logic signed [COORD_W-1:0] cent_q [4];
  logic signed [COORD_W-1:0] fresh_q [2];
  logic signed [SUM_W-1:0]   sum_q [4];
  logic [CNT_W-1:0]          n_q [2];
  logic [CNT_W-1:0]          count_q, i_q;
  logic                      csel_q, j_q;
  logic [2:0]                k_q;
  logic [Q_W-1:0]            maxs_q, last_q;
  logic [7:0]                pass_q;
  logic                      conv_q, cid_q;
  status_e                   status_q;
  logic [2*COORD_W-1:0]      prod_q;
  logic [DIST_W-1:0]         d0_q, d1_q;

  logic [2*COORD_W-1:0] point_mem [MAX_POINTS];
  logic                 cls_mem [MAX_POINTS];
  logic [2*COORD_W-1:0] pt_q;
  logic                 cls_q;

  logic                 m_valid_q;
  logic [1:0]           m_user_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic acc;
  cmd_e cmd;
  logic signed [COORD_W-1:0] in_x, in_y, px, py;
  logic [PIDX_W-1:0]         in_idx;
  logic                      not_full, out_free;

  assign acc      = s_axis_tvalid && s_axis_tready;
  assign cmd      = cmd_e'(s_axis_tuser);
  assign in_x     = s_axis_tdata[15:0];
  assign in_y     = s_axis_tdata[31:16];
  assign in_idx   = s_axis_tdata[32 +: PIDX_W];
  assign px       = pt_q[COORD_W-1:0];
  assign py       = pt_q[2*COORD_W-1:COORD_W];
  assign not_full = count_q < CNT_W'(MAX_POINTS);
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // shared multiplier operand select
  logic signed [COORD_W-1:0] ma, mb;
  logic signed [COORD_W:0]   mdiff;
  logic [COORD_W-1:0]        mabs;

  always_comb begin
    if (state_q == S_SD) begin
      ma = fresh_q[k_q[0]];
      mb = cent_q[{csel_q, k_q[0]}];
    end else begin
      ma = k_q[0] ? py : px;
      mb = cent_q[k_q[1:0]];
    end
    mdiff = {ma[COORD_W-1], ma} - {mb[COORD_W-1], mb};
    mabs  = mdiff[COORD_W] ? COORD_W'(-mdiff) : mdiff[COORD_W-1:0];
  end

  // divide / sqrt unit
  iter_req_t             req;
  logic [ARG_W-1:0]      arg;
  logic [SUM_W-1:0]      mag, num;
  logic signed [SUM_W-1:0] cur_sum;
  logic                  unit_done;
  logic [Q_W-1:0]        unit_res;
  logic signed [COORD_W-1:0] mean_val;

  always_comb begin
    cur_sum   = sum_q[{csel_q, j_q}];
    mag       = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
    num       = mag + SUM_W'(n_q[csel_q] >> 1);
    req.start = (state_q == S_DIV) || (state_q == S_SQ);
    req.op    = (state_q == S_SQ) ? OP_SQRT : OP_DIV;
    arg       = (state_q == S_SQ) ? ARG_W'(d0_q) : ARG_W'(num);
    mean_val  = cur_sum[SUM_W-1] ? COORD_W'(-unit_res) : unit_res[COORD_W-1:0];
  end

  kmtc_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .arg_i  (arg),
    .den_i  (n_q[csel_q]),
    .done_o (unit_done),
    .res_o  (unit_res)
  );

  // pass end decisions
  logic [7:0]     pass_inc, cap_eff;
  logic [Q_W-1:0] dd;
  logic           conv_now, cap_hit, cls_new;

  always_comb begin
    pass_inc = pass_q + 8'd1;
    cap_eff  = (cap_q == 8'd0) ? 8'd1 : cap_q;
    dd       = (maxs_q > last_q) ? maxs_q - last_q : last_q - maxs_q;
    conv_now = dd <= Q_W'(thr_q);
    cap_hit  = pass_inc >= cap_eff;
    cls_new  = d1_q < d0_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (cmd)
            CMD_RUN:  state_d = (count_q == '0) ? S_RESP : S_PINIT;
            CMD_READ: state_d = (CNT_W'(in_idx) >= count_q) ? S_RESP : S_READ;
            default:  state_d = S_RESP;
          endcase
        end
      end
      S_READ:   state_d = S_RESP;
      S_RESP:   if (out_free) state_d = S_IDLE;
      S_PINIT:  state_d = S_FETCH;
      S_FETCH:  state_d = S_DIST;
      S_DIST:   if (k_q == 3'd4) state_d = S_ASSIGN;
      S_ASSIGN: state_d = (i_q + 1'b1 == count_q) ? S_UPD : S_FETCH;
      S_UPD: begin
        if (n_q[csel_q] != '0) state_d = S_DIV;
        else if (csel_q) state_d = S_PEND;
      end
      S_DIV:    state_d = S_DIVW;
      S_DIVW:   if (unit_done) state_d = j_q ? S_SD : S_DIV;
      S_SD:     if (k_q == 3'd2) state_d = S_SQ;
      S_SQ:     state_d = S_SQW;
      S_SQW:    if (unit_done) state_d = csel_q ? S_PEND : S_UPD;
      S_PEND:   state_d = (conv_now || cap_hit) ? S_RESP : S_PINIT;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q[0] <= RST_C0_X;
      ic_q[1] <= RST_C0_Y;
      ic_q[2] <= RST_C1_X;
      ic_q[3] <= RST_C1_Y;
      thr_q   <= RST_THRESHOLD;
      cap_q   <= RST_CAP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_C0_X: ic_q[0] <= cfg_data_i;
        REG_C0_Y: ic_q[1] <= cfg_data_i;
        REG_C1_X: ic_q[2] <= cfg_data_i;
        REG_C1_Y: ic_q[3] <= cfg_data_i;
        REG_THR:  thr_q   <= cfg_data_i;
        REG_CAP:  cap_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // control and result state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cent_q[0] <= RST_C0_X;
      cent_q[1] <= RST_C0_Y;
      cent_q[2] <= RST_C1_X;
      cent_q[3] <= RST_C1_Y;
      count_q   <= '0;
      last_q    <= START_SHIFT;
      pass_q    <= '0;
      conv_q    <= 1'b0;
      status_q  <= ST_OK;
      cid_q     <= 1'b0;
      i_q       <= '0;
      csel_q    <= 1'b0;
      j_q       <= 1'b0;
      k_q       <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            status_q <= ST_OK;
            cid_q    <= 1'b0;
            unique case (cmd)
              CMD_LOAD: begin
                if (not_full) count_q <= count_q + 1'b1;
                else status_q <= ST_FULL;
              end
              CMD_RUN: begin
                if (count_q == '0) begin
                  status_q <= ST_EMPTY;
                end else begin
                  cent_q <= ic_q;
                  last_q <= START_SHIFT;
                  pass_q <= '0;
                  conv_q <= 1'b0;
                end
              end
              CMD_READ: if (CNT_W'(in_idx) >= count_q) status_q <= ST_BADIDX;
              CMD_CLEAR: count_q <= '0;
              default: ;
            endcase
          end
        end
        S_READ:  cid_q <= cls_q;
        S_PINIT: begin
          i_q    <= '0;
          csel_q <= 1'b0;
        end
        S_FETCH: k_q <= '0;
        S_DIST:  k_q <= k_q + 3'd1;
        S_ASSIGN: i_q <= i_q + 1'b1;
        S_UPD: begin
          j_q <= 1'b0;
          if (n_q[csel_q] == '0) csel_q <= 1'b1;
        end
        S_DIVW: begin
          if (unit_done) begin
            j_q <= 1'b1;
            k_q <= '0;
          end
        end
        S_SD: k_q <= k_q + 3'd1;
        S_SQW: begin
          if (unit_done) begin
            cent_q[{csel_q, 1'b0}] <= fresh_q[0];
            cent_q[{csel_q, 1'b1}] <= fresh_q[1];
            csel_q <= 1'b1;
          end
        end
        S_PEND: begin
          pass_q <= pass_inc;
          last_q <= maxs_q;
          if (conv_now) conv_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // pass datapath
  always_ff @(posedge clk_i) begin
    if (k_q < 3'd4) prod_q <= mabs * mabs;
    unique case (state_q)
      S_PINIT: begin
        for (int c = 0; c < 2; c++) n_q[c] <= '0;
        for (int e = 0; e < 4; e++) sum_q[e] <= '0;
        maxs_q <= '0;
      end
      S_DIST: begin
        unique case (k_q)
          3'd1: d0_q <= DIST_W'(prod_q);
          3'd2: d0_q <= d0_q + DIST_W'(prod_q);
          3'd3: d1_q <= DIST_W'(prod_q);
          3'd4: d1_q <= d1_q + DIST_W'(prod_q);
          default: ;
        endcase
      end
      S_ASSIGN: begin
        n_q[cls_new] <= n_q[cls_new] + 1'b1;
        sum_q[{cls_new, 1'b0}] <= sum_q[{cls_new, 1'b0}] +
                                  {{(SUM_W-COORD_W){px[COORD_W-1]}}, px};
        sum_q[{cls_new, 1'b1}] <= sum_q[{cls_new, 1'b1}] +
                                  {{(SUM_W-COORD_W){py[COORD_W-1]}}, py};
      end
      S_DIVW: if (unit_done) fresh_q[j_q] <= mean_val;
      S_SD: begin
        if (k_q == 3'd1) d0_q <= DIST_W'(prod_q);
        else if (k_q == 3'd2) d0_q <= d0_q + DIST_W'(prod_q);
      end
      S_SQW: if (unit_done && unit_res > maxs_q) maxs_q <= unit_res;
      default: ;
    endcase
  end

  // point and class memories
  logic              cls_we, cls_wd;
  logic [PIDX_W-1:0] cls_wa;

  always_comb begin
    if (state_q == S_ASSIGN) begin
      cls_we = 1'b1;
      cls_wa = i_q[PIDX_W-1:0];
      cls_wd = cls_new;
    end else begin
      cls_we = acc && (cmd == CMD_LOAD) && not_full;
      cls_wa = count_q[PIDX_W-1:0];
      cls_wd = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && (cmd == CMD_LOAD) && not_full) begin
      point_mem[count_q[PIDX_W-1:0]] <= {in_y, in_x};
    end
    pt_q <= point_mem[i_q[PIDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cls_we) cls_mem[cls_wa] <= cls_wd;
    cls_q <= cls_mem[in_idx];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_RESP && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP && out_free) begin
      m_user_q <= status_q;
      m_data_q <= {3'b000, cent_q[3], cent_q[2], cent_q[1], cent_q[0],
                   conv_q, pass_q, count_q, cid_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ASSIGN |-> i_q < count_q)
    else $error("point walk past count");
  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PINIT |-> count_q != '0)
    else $error("pass started with no points");
`endif

endmodule
